/* rtl/core/sfa_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the segment-fit allocator.
package sfa_pkg;

    localparam int MAX_SEGMENTS_DEF   = 64;
    localparam int POOL_ADDR_BITS_DEF = 20;
    localparam int POOL_RESET         = 1048576;

    // Fixed word field widths
    localparam int SIZE_W   = 21;
    localparam int OFF_W    = 20;
    localparam int STAT_W   = 3;
    localparam int COUNT_W  = 7;
    localparam int POLICY_W = 2;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 32;

    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NOFIT   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BADFREE = 3'd3;
    localparam logic [STAT_W-1:0] STAT_ZERO    = 3'd4;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_POOL   = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_NEXT  = 2'd1,
        POL_BEST  = 2'd2,
        POL_WORST = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_REBUILD,
        CMD_ALLOC,
        CMD_FREE
    } cell_op_t;

    // Update broadcast to every cell
    typedef struct packed {
        cell_op_t op;
        logic     split;  // alloc leaves a remainder hole
        logic     lm;     // free merges with left hole
        logic     rm;     // free merges with right hole
    } cell_cmd_t;

endpackage

/* rtl/core/sfa_cell.sv */
`timescale 1ns / 1ps
// One table entry of the allocator with its slice of the search chain.
module sfa_cell #(
    parameter int IDX = 0,
    parameter int AW  = 20,
    parameter int LW  = 21,
    parameter int IW  = 6,
    parameter int CW  = 7,
    parameter int SW  = 22
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sfa_pkg::cell_cmd_t    cmd,
    input  logic [IW-1:0]         tgt,
    input  logic [SW-1:0]         size,
    input  logic [LW-1:0]         pool_len,
    input  logic [CW-1:0]         total,
    input  logic [1:0]            policy,
    input  logic [IW-1:0]         start,
    input  logic [19:0]           foff,
    // neighbors
    input  logic [AW-1:0]         l_off,
    input  logic [LW-1:0]         l_len,
    input  logic                  l_used,
    input  logic [AW-1:0]         r_off,
    input  logic [LW-1:0]         r_len,
    input  logic                  r_used,
    input  logic [AW-1:0]         r2_off,
    input  logic [LW-1:0]         r2_len,
    input  logic                  r2_used,
    output logic [AW-1:0]         off,
    output logic [LW-1:0]         len,
    output logic                  used,
    // search chain in
    input  logic                  ai_v,
    input  logic [IW-1:0]         ai_idx,
    input  logic [AW-1:0]         ai_off,
    input  logic [LW-1:0]         ai_len,
    input  logic                  bi_v,
    input  logic [IW-1:0]         bi_idx,
    input  logic [AW-1:0]         bi_off,
    input  logic [LW-1:0]         bi_len,
    input  logic                  fi_v,
    input  logic [IW-1:0]         fi_idx,
    input  logic                  fi_lm,
    input  logic                  fi_rm,
    // search chain out
    output logic                  ao_v,
    output logic [IW-1:0]         ao_idx,
    output logic [AW-1:0]         ao_off,
    output logic [LW-1:0]         ao_len,
    output logic                  bo_v,
    output logic [IW-1:0]         bo_idx,
    output logic [AW-1:0]         bo_off,
    output logic [LW-1:0]         bo_len,
    output logic                  fo_v,
    output logic [IW-1:0]         fo_idx,
    output logic                  fo_lm,
    output logic                  fo_rm
);
    import sfa_pkg::*;

    localparam int FW = (AW > 20) ? AW : 20;
    localparam longint LIM = longint'(1) << AW;
    localparam longint RL  = (longint'(POOL_RESET) > LIM) ? LIM : longint'(POOL_RESET);
    localparam logic [LW-1:0] RESET_LEN = (IDX == 0) ? LW'(RL) : '0;
    localparam logic [CW-1:0] MY  = CW'(IDX);
    localparam logic [IW-1:0] MYI = IW'(IDX);

    logic [AW-1:0] off_reg, off_next;
    logic [LW-1:0] len_reg, len_next;
    logic          used_reg, used_next;

    logic          a_v_reg, a_v_next, b_v_reg, b_v_next, f_v_reg, f_v_next;
    logic [IW-1:0] a_idx_reg, a_idx_next, b_idx_reg, b_idx_next, f_idx_reg, f_idx_next;
    logic [AW-1:0] a_off_reg, a_off_next, b_off_reg, b_off_next;
    logic [LW-1:0] a_len_reg, a_len_next, b_len_reg, b_len_next;
    logic          f_lm_reg, f_lm_next, f_rm_reg, f_rm_next;

    logic          here, fit, take_a;
    logic [CW-1:0] t_ext;

    assign here  = MY < total;
    assign fit   = here && !used_reg && (SW'(len_reg) >= size);
    assign t_ext = CW'(tgt);

    // search step
    always_comb
    begin
        take_a = 1'b0;
        if (fit)
        begin
            if (!ai_v)
                take_a = 1'b1;
            else if (policy == POL_BEST && len_reg < ai_len)
                take_a = 1'b1;
            else if (policy == POL_WORST && len_reg > ai_len)
                take_a = 1'b1;
        end
        a_v_next   = ai_v;
        a_idx_next = ai_idx;
        a_off_next = ai_off;
        a_len_next = ai_len;
        if (take_a)
        begin
            a_v_next   = 1'b1;
            a_idx_next = MYI;
            a_off_next = off_reg;
            a_len_next = len_reg;
        end
        b_v_next   = bi_v;
        b_idx_next = bi_idx;
        b_off_next = bi_off;
        b_len_next = bi_len;
        if (fit && !bi_v && (MYI >= start))
        begin
            b_v_next   = 1'b1;
            b_idx_next = MYI;
            b_off_next = off_reg;
            b_len_next = len_reg;
        end
        f_v_next   = fi_v;
        f_idx_next = fi_idx;
        f_lm_next  = fi_lm;
        f_rm_next  = fi_rm;
        if (here && used_reg && !fi_v && (FW'(off_reg) == FW'(foff)))
        begin
            f_v_next   = 1'b1;
            f_idx_next = MYI;
            f_lm_next  = (IDX > 0) && !l_used;
            f_rm_next  = ((MY + CW'(1)) < total) && !r_used;
        end
    end

    // table update
    always_comb
    begin
        off_next  = off_reg;
        len_next  = len_reg;
        used_next = used_reg;
        case (cmd.op)
            CMD_REBUILD:
            begin
                if (IDX == 0)
                begin
                    off_next  = '0;
                    len_next  = pool_len;
                    used_next = 1'b0;
                end
            end
            CMD_ALLOC:
            begin
                if (MY == t_ext)
                begin
                    used_next = 1'b1;
                    if (cmd.split)
                        len_next = LW'(size);
                end
                else if (cmd.split && MY == t_ext + CW'(1))
                begin
                    off_next  = l_off + AW'(size);
                    len_next  = l_len - LW'(size);
                    used_next = 1'b0;
                end
                else if (cmd.split && MY > t_ext + CW'(1))
                begin
                    off_next  = l_off;
                    len_next  = l_len;
                    used_next = l_used;
                end
            end
            CMD_FREE:
            begin
                if (cmd.lm)
                begin
                    if (MY + CW'(1) == t_ext)
                        len_next = len_reg + r_len + (cmd.rm ? r2_len : '0);
                    else if (MY >= t_ext)
                    begin
                        off_next  = cmd.rm ? r2_off  : r_off;
                        len_next  = cmd.rm ? r2_len  : r_len;
                        used_next = cmd.rm ? r2_used : r_used;
                    end
                end
                else
                begin
                    if (MY == t_ext)
                    begin
                        used_next = 1'b0;
                        len_next  = len_reg + (cmd.rm ? r_len : '0);
                    end
                    else if (cmd.rm && MY > t_ext)
                    begin
                        off_next  = r_off;
                        len_next  = r_len;
                        used_next = r_used;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg  <= '0;
            len_reg  <= RESET_LEN;
            used_reg <= 1'b0;
            a_v_reg  <= 1'b0;
            b_v_reg  <= 1'b0;
            f_v_reg  <= 1'b0;
        end
        else
        begin
            off_reg  <= off_next;
            len_reg  <= len_next;
            used_reg <= used_next;
            a_v_reg  <= a_v_next;
            b_v_reg  <= b_v_next;
            f_v_reg  <= f_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_idx_reg <= a_idx_next;
        a_off_reg <= a_off_next;
        a_len_reg <= a_len_next;
        b_idx_reg <= b_idx_next;
        b_off_reg <= b_off_next;
        b_len_reg <= b_len_next;
        f_idx_reg <= f_idx_next;
        f_lm_reg  <= f_lm_next;
        f_rm_reg  <= f_rm_next;
    end

    assign off    = off_reg;
    assign len    = len_reg;
    assign used   = used_reg;
    assign ao_v   = a_v_reg;
    assign ao_idx = a_idx_reg;
    assign ao_off = a_off_reg;
    assign ao_len = a_len_reg;
    assign bo_v   = b_v_reg;
    assign bo_idx = b_idx_reg;
    assign bo_off = b_off_reg;
    assign bo_len = b_len_reg;
    assign fo_v   = f_v_reg;
    assign fo_idx = f_idx_reg;
    assign fo_lm  = f_lm_reg;
    assign fo_rm  = f_rm_reg;

endmodule

/* rtl/core/segment_fit_allocator.sv */
`timescale 1ns / 1ps
// Top level of the segment-fit pool allocator.
//
// Pool allocator over an address-ordered table of up to MAX_SEGMENTS segments,
// one per cell of a chain. Each word on s_* is an allocate (size rounded up to
// a multiple of 4, hole picked by first, next, best or worst fit per
// alloc_policy) or a free (by start offset, merged with neighboring holes).
// Each request returns one word on m_* with status, granted offset and the
// segment count after the request. The search result ripples one cell per
// clock down the chain, then the commit state applies the insert or delete
// shift across all cells at once. One request is in flight at a time; a new
// word is taken while the previous result still waits on m_*, and the next
// commit waits for that result to leave. Writing either register (cfg_we)
// rebuilds the table as one hole and clears the next-fit cursor; write only
// while no request is in flight. s_tready drops in a cycle with a register
// write.
module segment_fit_allocator #(
    parameter int MAX_SEGMENTS   = sfa_pkg::MAX_SEGMENTS_DEF,
    parameter int POOL_ADDR_BITS = sfa_pkg::POOL_ADDR_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // command[0], request_size[21:1], free_offset[41:22], zero fill
    input  logic [sfa_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // status[2:0], granted_offset[22:3], segment_count[29:23], zero fill
    output logic [sfa_pkg::OUT_W-1:0] m_tdata,
    input  logic                      cfg_we,
    input  logic                      cfg_addr,
    input  logic [sfa_pkg::SIZE_W-1:0] cfg_wdata
);
    import sfa_pkg::*;

    localparam int AW = POOL_ADDR_BITS;
    localparam int LW = AW + 1;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int SW = (LW > 22) ? LW : 22;
    localparam int N  = MAX_SEGMENTS;

    // pool size rounded up to 4 and saturated at the address range
    function automatic logic [LW-1:0] pool_len_of(input logic [SIZE_W-1:0] v);
        logic [22:0] r;
        logic [33:0] t;
        logic [33:0] lim;
        r   = (23'(v) + 23'd3) & ~23'd3;
        t   = 34'(r);
        lim = 34'd1 << AW;
        return (t > lim) ? LW'(lim) : LW'(t);
    endfunction

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                op_reg;
    logic [SW-1:0]       size_reg;
    logic [OFF_W-1:0]    foff_reg;
    logic [1:0]          policy_reg;
    logic [SIZE_W-1:0]   pool_reg;
    logic [CW-1:0]       total_reg, total_next;
    logic [IW-1:0]       cursor_reg, cursor_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [STAT_W-1:0]   stat_reg, stat_next;
    logic [OFF_W-1:0]    grant_reg, grant_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    cell_cmd_t           cmd;
    logic [IW-1:0]       tgt;
    logic [LW-1:0]       pool_len;
    logic [IW-1:0]       start;
    logic                out_free;
    logic                accept;
    logic [SW-1:0]       req_size;

    // per-cell taps
    logic [AW-1:0] c_off  [N+2];
    logic [LW-1:0] c_len  [N+2];
    logic          c_used [N+2];
    logic          a_v   [N+1];
    logic [IW-1:0] a_idx [N+1];
    logic [AW-1:0] a_off [N+1];
    logic [LW-1:0] a_len [N+1];
    logic          b_v   [N+1];
    logic [IW-1:0] b_idx [N+1];
    logic [AW-1:0] b_off [N+1];
    logic [LW-1:0] b_len [N+1];
    logic          f_v   [N+1];
    logic [IW-1:0] f_idx [N+1];
    logic          f_lm  [N+1];
    logic          f_rm  [N+1];

    // search chain entry and beyond-the-end neighbors
    assign a_v[0]   = 1'b0;
    assign a_idx[0] = '0;
    assign a_off[0] = '0;
    assign a_len[0] = '0;
    assign b_v[0]   = 1'b0;
    assign b_idx[0] = '0;
    assign b_off[0] = '0;
    assign b_len[0] = '0;
    assign f_v[0]   = 1'b0;
    assign f_idx[0] = '0;
    assign f_lm[0]  = 1'b0;
    assign f_rm[0]  = 1'b0;
    assign c_off[N]    = '0;
    assign c_len[N]    = '0;
    assign c_used[N]   = 1'b1;
    assign c_off[N+1]  = '0;
    assign c_len[N+1]  = '0;
    assign c_used[N+1] = 1'b1;

    assign start = (CW'(cursor_reg) < total_reg) ? cursor_reg : '0;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            logic [AW-1:0] lo;
            logic [LW-1:0] ll;
            logic          lu;
            if (g == 0)
            begin : g_first
                assign lo = '0;
                assign ll = '0;
                assign lu = 1'b1;
            end
            else
            begin : g_rest
                assign lo = c_off[g-1];
                assign ll = c_len[g-1];
                assign lu = c_used[g-1];
            end
            sfa_cell #(
                .IDX (g),
                .AW  (AW),
                .LW  (LW),
                .IW  (IW),
                .CW  (CW),
                .SW  (SW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .tgt      (tgt),
                .size     (size_reg),
                .pool_len (pool_len),
                .total    (total_reg),
                .policy   (policy_reg),
                .start    (start),
                .foff     (foff_reg),
                .l_off    (lo),
                .l_len    (ll),
                .l_used   (lu),
                .r_off    (c_off[g+1]),
                .r_len    (c_len[g+1]),
                .r_used   (c_used[g+1]),
                .r2_off   (c_off[g+2]),
                .r2_len   (c_len[g+2]),
                .r2_used  (c_used[g+2]),
                .off      (c_off[g]),
                .len      (c_len[g]),
                .used     (c_used[g]),
                .ai_v     (a_v[g]),
                .ai_idx   (a_idx[g]),
                .ai_off   (a_off[g]),
                .ai_len   (a_len[g]),
                .bi_v     (b_v[g]),
                .bi_idx   (b_idx[g]),
                .bi_off   (b_off[g]),
                .bi_len   (b_len[g]),
                .fi_v     (f_v[g]),
                .fi_idx   (f_idx[g]),
                .fi_lm    (f_lm[g]),
                .fi_rm    (f_rm[g]),
                .ao_v     (a_v[g+1]),
                .ao_idx   (a_idx[g+1]),
                .ao_off   (a_off[g+1]),
                .ao_len   (a_len[g+1]),
                .bo_v     (b_v[g+1]),
                .bo_idx   (b_idx[g+1]),
                .bo_off   (b_off[g+1]),
                .bo_len   (b_len[g+1]),
                .fo_v     (f_v[g+1]),
                .fo_idx   (f_idx[g+1]),
                .fo_lm    (f_lm[g+1]),
                .fo_rm    (f_rm[g+1])
            );
        end
    endgenerate

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && !cfg_we;
    assign accept   = s_tvalid && s_tready;
    assign req_size = (SW'(s_tdata[21:1]) + SW'(3)) & ~SW'(3);
    assign pool_len = pool_len_of((cfg_addr == REG_POOL) ? cfg_wdata : pool_reg);

    // sequencer and commit decision
    always_comb
    begin
        logic          pk_v;
        logic [IW-1:0] pk_idx;
        logic [AW-1:0] pk_off;
        logic [LW-1:0] pk_len;
        logic          split;
        logic [IW-1:0] cur;
        logic [CW-1:0] fi;

        state_next    = state_reg;
        cnt_next      = cnt_reg;
        total_next    = total_reg;
        cursor_next   = cursor_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        stat_next     = stat_reg;
        grant_next    = grant_reg;
        count_next    = count_reg;
        cmd           = '{op: CMD_NONE, split: 1'b0, lm: 1'b0, rm: 1'b0};
        tgt           = '0;

        pk_v   = (policy_reg == POL_NEXT && b_v[N]) ? 1'b1       : a_v[N];
        pk_idx = (policy_reg == POL_NEXT && b_v[N]) ? b_idx[N]   : a_idx[N];
        pk_off = (policy_reg == POL_NEXT && b_v[N]) ? b_off[N]   : a_off[N];
        pk_len = (policy_reg == POL_NEXT && b_v[N]) ? b_len[N]   : a_len[N];
        split  = SW'(pk_len) > size_reg;
        cur    = cursor_reg;
        fi     = CW'(f_idx[N]);

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    cmd.op      = CMD_REBUILD;
                    total_next  = CW'(1);
                    cursor_next = '0;
                end
                else if (accept)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                // step down the chain until the result at its end has settled
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(N - 1))
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    grant_next    = '0;
                    if (op_reg == OP_ALLOC)
                    begin
                        if (size_reg == '0)
                            stat_next = STAT_ZERO;
                        else if (!pk_v)
                        begin
                            stat_next = STAT_NOFIT;
                            if (policy_reg == POL_NEXT)
                                cursor_next = '0;
                        end
                        else if (split && total_reg >= CW'(N))
                            stat_next = STAT_FULL;
                        else
                        begin
                            stat_next  = STAT_OK;
                            grant_next = OFF_W'(pk_off);
                            cmd.op     = CMD_ALLOC;
                            cmd.split  = split;
                            tgt        = pk_idx;
                            if (split)
                            begin
                                total_next = total_reg + CW'(1);
                                if (CW'(cur) >= CW'(pk_idx) + CW'(1))
                                    cur = cur + IW'(1);
                            end
                            if (policy_reg == POL_NEXT)
                                cur = pk_idx;
                            cursor_next = cur;
                        end
                    end
                    else
                    begin
                        if (!f_v[N])
                            stat_next = STAT_BADFREE;
                        else
                        begin
                            stat_next = STAT_OK;
                            cmd.op    = CMD_FREE;
                            cmd.lm    = f_lm[N];
                            cmd.rm    = f_rm[N];
                            tgt       = f_idx[N];
                            total_next = total_reg - CW'(f_lm[N]) - CW'(f_rm[N]);
                            // cursor follows the removed entries, right one first
                            if (f_rm[N] && CW'(cur) >= fi + CW'(1) && cur != '0)
                                cur = cur - IW'(1);
                            if (f_lm[N] && CW'(cur) >= fi && cur != '0)
                                cur = cur - IW'(1);
                            cursor_next = cur;
                        end
                    end
                    count_next = COUNT_W'(total_next);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            total_reg    <= CW'(1);
            cursor_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            policy_reg   <= POL_FIRST;
            pool_reg     <= SIZE_W'(POOL_RESET);
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            total_reg    <= total_next;
            cursor_reg   <= cursor_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we && cfg_addr == REG_POLICY)
                policy_reg <= cfg_wdata[1:0];
            if (cfg_we && cfg_addr == REG_POOL)
                pool_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_tdata[0];
            size_reg <= req_size;
            foff_reg <= s_tdata[41:22];
        end
        stat_reg  <= stat_next;
        grant_reg <= grant_next;
        count_reg <= count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, count_reg, grant_reg, stat_reg};

endmodule

/* rtl/core/sfa_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the segment-fit allocator and their binding.
module sfa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import sfa_pkg::*;

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // status code range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= STAT_ZERO)
        else $error("status out of range");

    // no grant offset on a failed request
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] != STAT_OK |-> m_tdata[22:3] == 20'd0)
        else $error("nonzero offset on failed request");

    // table never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[29:23] != 7'd0)
        else $error("segment count zero");

    // one request in flight: no intake right after an accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

endmodule

bind segment_fit_allocator sfa_checker u_sfa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* dv/segment_fit_allocator_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the segment-fit pool allocator.
module segment_fit_allocator_test;
    import sfa_pkg::*;

    localparam int SEGS       = MAX_SEGMENTS_DEF;
    localparam int POOL_MAX   = 1 << POOL_ADDR_BITS_DEF;
    localparam int DONE_WAIT  = 200;   // idle wait before the final check
    localparam int STALL_MAX  = 3000;  // cycles with no word moving
    localparam int HOLD_LEN   = 400;   // long receiver hold-off

    typedef struct {
        logic              cmd;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  off;
        bit                live;   // pick a live segment when presented
        bit                drain;  // wait for all results before presenting
    } req_t;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [OFF_W-1:0]   granted;
        logic [COUNT_W-1:0] count;
    } resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic cfg_addr = REG_POLICY;
    logic [SIZE_W-1:0] cfg_wdata = '0;

    segment_fit_allocator u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the segment table
    logic [SIZE_W-1:0] tbl_off [SEGS];
    logic [SIZE_W-1:0] tbl_len [SEGS];
    bit                tbl_used [SEGS];
    int                tbl_n;
    int                cursor;
    policy_t           policy;
    logic [SIZE_W-1:0] pool_reg;

    req_t  pending [$];
    resp_t expected [$];
    req_t  cur;
    int    errors = 0;
    bit    steady = 1'b0;      // no random idling on either side
    int    hold_req = 0;
    int    hold_seen = 0;
    int    hold_cnt = 0;
    int    quiet = 0;

    function automatic void rebuild_table();
        logic [SIZE_W+1:0] len;
        len = ({2'b0, pool_reg} + 3) & ~23'd3;
        if (len > POOL_MAX)
            len = POOL_MAX;
        tbl_off[0] = '0;
        tbl_len[0] = len[SIZE_W-1:0];
        tbl_used[0] = 1'b0;
        tbl_n = 1;
        cursor = 0;
    endfunction

    function automatic void drop_entry(int d);
        for (int i = d; i < tbl_n - 1; i++)
        begin
            tbl_off[i] = tbl_off[i+1];
            tbl_len[i] = tbl_len[i+1];
            tbl_used[i] = tbl_used[i+1];
        end
        tbl_n--;
        if (cursor >= d && cursor > 0)
            cursor--;
    endfunction

    function automatic void open_entry(int p);
        for (int i = tbl_n; i > p; i--)
        begin
            tbl_off[i] = tbl_off[i-1];
            tbl_len[i] = tbl_len[i-1];
            tbl_used[i] = tbl_used[i-1];
        end
        tbl_n++;
        if (cursor >= p)
            cursor++;
    endfunction

    function automatic logic [STAT_W-1:0] allocate(logic [SIZE_W-1:0] req,
                                                   output logic [OFF_W-1:0] grant);
        logic [SIZE_W+1:0] want;
        int pick;
        int idx;
        int start;
        want = ({2'b0, req} + 3) & ~23'd3;
        pick = tbl_n;
        grant = '0;
        if (want == 0)
            return STAT_ZERO;
        if (policy == POL_NEXT)
        begin
            start = (cursor < tbl_n) ? cursor : 0;
            for (int i = 0; i < tbl_n; i++)
            begin
                idx = (start + i) % tbl_n;
                if (!tbl_used[idx] && tbl_len[idx] >= want)
                begin
                    pick = idx;
                    break;
                end
            end
        end
        else
        begin
            for (int i = 0; i < tbl_n; i++)
            begin
                if (tbl_used[i] || tbl_len[i] < want)
                    continue;
                if (pick == tbl_n)
                begin
                    pick = i;
                    if (policy == POL_FIRST)
                        break;
                end
                else if (policy == POL_BEST && tbl_len[i] < tbl_len[pick])
                    pick = i;
                else if (policy == POL_WORST && tbl_len[i] > tbl_len[pick])
                    pick = i;
            end
        end
        if (pick >= tbl_n)
        begin
            if (policy == POL_NEXT)
                cursor = 0;
            return STAT_NOFIT;
        end
        if (tbl_len[pick] > want)
        begin
            if (tbl_n >= SEGS)
                return STAT_FULL;
            open_entry(pick + 1);
            tbl_off[pick+1] = tbl_off[pick] + want;
            tbl_len[pick+1] = tbl_len[pick] - want;
            tbl_used[pick+1] = 1'b0;
            tbl_len[pick] = want;
        end
        tbl_used[pick] = 1'b1;
        if (policy == POL_NEXT)
            cursor = pick;
        grant = tbl_off[pick][OFF_W-1:0];
        return STAT_OK;
    endfunction

    function automatic logic [STAT_W-1:0] release_seg(logic [OFF_W-1:0] off);
        int i;
        for (i = 0; i < tbl_n; i++)
            if (tbl_used[i] && tbl_off[i] == off)
                break;
        if (i >= tbl_n)
            return STAT_BADFREE;
        tbl_used[i] = 1'b0;
        if (i + 1 < tbl_n && !tbl_used[i+1])
        begin
            tbl_len[i] += tbl_len[i+1];
            drop_entry(i + 1);
        end
        if (i > 0 && !tbl_used[i-1])
        begin
            tbl_len[i-1] += tbl_len[i];
            drop_entry(i);
        end
        return STAT_OK;
    endfunction

    // Offset of a random allocated segment, or a random offset if none is live
    function automatic logic [OFF_W-1:0] live_offset();
        int live [$];
        for (int i = 0; i < tbl_n; i++)
            if (tbl_used[i])
                live.push_back(i);
        if (live.size() == 0)
            return $urandom();
        return tbl_off[live[$urandom_range(live.size() - 1)]][OFF_W-1:0];
    endfunction

    // Driver: predicts on acceptance, then loads the next word
    always @(posedge clk or negedge rst_n)
    begin
        resp_t r;
        bit    offer;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (cur.cmd == OP_ALLOC)
                    r.status = allocate(cur.size, r.granted);
                else
                begin
                    r.status = release_seg(cur.off);
                    r.granted = '0;
                end
                r.count = tbl_n[COUNT_W-1:0];
                expected.push_back(r);
            end
            if (!(s_tvalid && !s_tready))
            begin
                offer = pending.size() != 0 && (steady || $urandom_range(99) >= 30);
                if (offer && pending[0].drain && expected.size() != 0)
                    offer = 1'b0;
                if (offer)
                begin
                    cur = pending.pop_front();
                    if (cur.live)
                        cur.off = live_offset();
                    s_tdata <= {{(IN_W - 1 - SIZE_W - OFF_W){1'b0}}, cur.off, cur.size, cur.cmd};
                end
                s_tvalid <= offer;
            end
        end
    end

    // Result side: random stalls, one long hold-off, field checks
    always @(posedge clk or negedge rst_n)
    begin
        resp_t e;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    e = expected.pop_front();
                    if (m_tdata[2:0] !== e.status)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, e.status, m_tdata[2:0]);
                        errors++;
                    end
                    if (m_tdata[22:3] !== e.granted)
                    begin
                        $display("%0t: offset exp %h got %h", $time, e.granted, m_tdata[22:3]);
                        errors++;
                    end
                    if (m_tdata[29:23] !== e.count)
                    begin
                        $display("%0t: count exp %0d got %0d", $time, e.count, m_tdata[29:23]);
                        errors++;
                    end
                end
            end
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_cnt = HOLD_LEN;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || $urandom_range(99) >= 30;
        end
    end

    // Watchdog on word movement
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet <= 0;
        else if (quiet >= STALL_MAX)
        begin
            $display("[segment_fit_allocator] ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic push_alloc(int unsigned sz);
        req_t q;
        q = '{cmd: OP_ALLOC, size: sz[SIZE_W-1:0], off: '0, live: 1'b0, drain: 1'b0};
        pending.push_back(q);
    endtask

    task automatic push_free(int unsigned off, bit live);
        req_t q;
        q = '{cmd: OP_FREE, size: '0, off: off[OFF_W-1:0], live: live, drain: 1'b0};
        pending.push_back(q);
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || expected.size() != 0 || s_tvalid)
            @(posedge clk);
    endtask

    // Register write while idle; shadow table follows
    task automatic write_reg(logic addr, logic [SIZE_W-1:0] val);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        if (addr == REG_POLICY)
            policy = policy_t'(val[POLICY_W-1:0]);
        else
            pool_reg = val;
        rebuild_table();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly allocates and frees of live segments, some noise
    task automatic random_burst(int count, int unsigned max_sz);
        int unsigned k;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(99);
            if (k < 52)
                push_alloc($urandom_range(max_sz, 1));
            else if (k < 55)
                push_alloc($urandom_range(POOL_MAX, 0));
            else if (k < 57)
                push_alloc(0);
            else if (k < 92)
                push_free(0, 1'b1);
            else
                push_free($urandom(), 1'b0);
        end
    endtask

    logic [SIZE_W-1:0] pools [4] = '{21'd256, 21'd1001, 21'd65536, 21'd1048576};

    initial
    begin
        policy = POL_FIRST;
        pool_reg = POOL_RESET;
        rebuild_table();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero size, rounding, no fit, bad frees, exact fit
        push_alloc(0);
        push_alloc(1);
        push_alloc(POOL_MAX);
        push_alloc(3);
        push_free(0, 1'b0);
        push_free(0, 1'b0);
        push_free(20'hFFFFF, 1'b0);
        push_free(4, 1'b0);
        push_alloc(POOL_MAX);
        push_free(0, 1'b0);
        push_alloc(21'h1FFFFF & (POOL_MAX - 1));
        push_alloc(5);
        wait_idle();
        write_reg(REG_POOL, 21'd4);
        push_alloc(4);
        push_alloc(4);
        push_free(0, 1'b0);
        push_alloc(2);
        wait_idle();

        // Random phases across every policy and several pool sizes
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_POLICY, ph % 4);
            write_reg(REG_POOL, pools[(ph / 4 + ph) % 4]);
            steady = (ph == 2);
            random_burst(120, (pool_reg > 4096) ? 4096 : pool_reg / 8 + 4);
            // long receiver hold-off while words keep coming
            if (ph == 3)
                hold_req++;
            // sender waits for every result before going on
            pending[$].drain = 1'b1;
            random_burst(110, (pool_reg > 4096) ? 300 : pool_reg / 4 + 4);
            wait_idle();
        end
        write_reg(REG_POOL, POOL_RESET);
        write_reg(REG_POLICY, POL_NEXT);
        random_burst(100, 20000);
        wait_idle();
        steady = 1'b0;

        repeat (DONE_WAIT) @(posedge clk);
        if (errors == 0 && expected.size() == 0)
            $display("[segment_fit_allocator] OK");
        else
            $display("[segment_fit_allocator] ERROR");
        $finish;
    end

endmodule
